[src/scf_pkg.sv]
// Shared types and constants for the sum-checked frame receiver.
// No dependencies.
package scf_pkg;

    localparam int P_PAYLOAD_BOUND = 32;
    localparam int SLOT_CNT        = 4;
    localparam int SLOT_W          = 2;
    localparam int LEN_W           = 6;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] ID_LIMIT   = 8'hF1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_ACTIVE = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [7:0]       msg_id;
        logic [LEN_W-1:0] length;
    } t_desc;

endpackage

[src/scf_front.sv]
// Byte parser: header/id/length/payload/checksum state machine.
// Writes payload into the back end's buffer and queues a frame descriptor.
// Depends on scf_pkg.
module scf_front import scf_pkg::*; #(
    parameter int PAYLOAD_BOUND = P_PAYLOAD_BOUND,
    localparam int IDX_W = $clog2(PAYLOAD_BOUND)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_rx_byte,
    output t_desc                   o_desc,
    output logic                    o_push,
    input  logic                    i_frame_done,
    output logic                    o_wr_en,
    output logic [SLOT_W+IDX_W-1:0] o_wr_addr,
    output logic [7:0]              o_wr_data
);

    t_phase              r_phase, n_phase;
    logic [7:0]          r_sum;
    logic [IDX_W-1:0]    r_count;
    logic [7:0]          r_id;
    logic [LEN_W-1:0]    r_len;
    logic [SLOT_W-1:0]   r_wr_slot;
    logic [SLOT_W:0]     r_inflight;

    logic                accept;
    logic [LEN_W-1:0]    count_inc;
    logic                len_ok;

    assign o_ready   = (r_inflight != (SLOT_W+1)'(SLOT_CNT));
    assign accept    = i_valid && o_ready;
    assign count_inc = LEN_W'(r_count) + LEN_W'(1);
    assign len_ok    = (i_rx_byte < 8'(PAYLOAD_BOUND));

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: n_phase = (i_rx_byte == HDR_FIRST)  ? PH_HDR2 : PH_HUNT;
                PH_HDR2: n_phase = (i_rx_byte == HDR_SECOND) ? PH_ID   : PH_HUNT;
                PH_ID:   n_phase = (i_rx_byte < ID_LIMIT)    ? PH_LEN  : PH_HUNT;
                PH_LEN:  n_phase = len_ok ? PH_DATA : PH_HUNT;
                PH_DATA: begin
                    if (r_len == '0)
                        n_phase = PH_HUNT;
                    else if (count_inc == r_len)
                        n_phase = PH_SUM;
                    else
                        n_phase = PH_DATA;
                end
                PH_SUM:  n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        o_wr_en   = accept && (r_phase == PH_DATA) && (r_len != '0);
        o_push    = accept && (r_phase == PH_SUM) && (r_sum == i_rx_byte);
        o_wr_addr = {r_wr_slot, r_count};
        o_wr_data = i_rx_byte;
        o_desc.msg_id = r_id;
        o_desc.length = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_sum      <= '0;
            r_count    <= '0;
            r_id       <= '0;
            r_len      <= '0;
            r_wr_slot  <= '0;
            r_inflight <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                r_sum <= (r_phase == PH_HUNT) ? i_rx_byte : r_sum + i_rx_byte;
                if (r_phase == PH_ID)
                    r_id <= i_rx_byte;
                if (r_phase == PH_LEN) begin
                    r_len   <= i_rx_byte[LEN_W-1:0];
                    r_count <= '0;
                end
                if (o_wr_en)
                    r_count <= r_count + IDX_W'(1);
            end
            if (o_push)
                r_wr_slot <= r_wr_slot + SLOT_W'(1);
            if (o_push && !i_frame_done)
                r_inflight <= r_inflight + (SLOT_W+1)'(1);
            else if (!o_push && i_frame_done)
                r_inflight <= r_inflight - (SLOT_W+1)'(1);
        end
    end

endmodule

[src/scf_fifo.sv]
// Small descriptor queue between parser and emitter.
// Depends on scf_pkg.
module scf_fifo import scf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_empty,
    output logic  o_full
);

    t_desc             r_mem [SLOT_CNT];
    logic [SLOT_W-1:0] r_wr_ptr;
    logic [SLOT_W-1:0] r_rd_ptr;
    logic [SLOT_W:0]   r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (SLOT_W+1)'(SLOT_CNT));

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + SLOT_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + SLOT_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + (SLOT_W+1)'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - (SLOT_W+1)'(1);
        end
    end

endmodule

[src/scf_back.sv]
// Payload buffer and emitter: reads a stored frame slot and sends one
// transaction per payload byte through a registered output stage.
// Depends on scf_pkg.
module scf_back import scf_pkg::*; #(
    parameter int PAYLOAD_BOUND = P_PAYLOAD_BOUND,
    localparam int IDX_W = $clog2(PAYLOAD_BOUND),
    localparam int DEPTH = SLOT_CNT * (2 ** IDX_W)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [SLOT_W+IDX_W-1:0] i_wr_addr,
    input  logic [7:0]              i_wr_data,
    input  t_desc                   i_desc,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_frame_done,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_msg_id,
    output logic [4:0]              o_frame_length,
    output logic [4:0]              o_byte_index,
    output logic [7:0]              o_payload_byte,
    output logic                    o_last
);

    logic [7:0]        r_mem [DEPTH];

    t_back_state       r_state, n_state;
    t_desc             r_cur;
    logic [IDX_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_rd_slot;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_last;
    t_desc             r_s1_desc;
    logic [7:0]        r_rd_data;

    logic              r_out_valid;
    logic [7:0]        r_out_id;
    logic [4:0]        r_out_len;
    logic [4:0]        r_out_idx;
    logic [7:0]        r_out_data;
    logic              r_out_last;

    logic              out_free;
    logic              s1_free;
    logic              issue;
    logic              last_issue;

    assign out_free   = !r_out_valid || i_ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign last_issue = issue && ((LEN_W'(r_idx) + LEN_W'(1)) == r_cur.length);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (!i_empty) n_state = BK_ACTIVE;
            BK_ACTIVE: if (last_issue) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = (r_state == BK_IDLE) && !i_empty;
        issue        = (r_state == BK_ACTIVE) && s1_free;
        o_frame_done = last_issue;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
        if (issue)
            r_rd_data <= r_mem[{r_rd_slot, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        if (issue) begin
            r_s1_idx  <= r_idx;
            r_s1_last <= last_issue;
            r_s1_desc <= r_cur;
        end
        if (r_s1_valid && out_free) begin
            r_out_id   <= r_s1_desc.msg_id;
            r_out_len  <= 5'(r_s1_desc.length);
            r_out_idx  <= 5'(r_s1_idx);
            r_out_data <= r_rd_data;
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_rd_slot   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop)
                r_idx <= '0;
            else if (issue)
                r_idx <= r_idx + IDX_W'(1);
            if (last_issue)
                r_rd_slot <= r_rd_slot + SLOT_W'(1);
            if (s1_free)
                r_s1_valid <= issue;
            if (out_free)
                r_out_valid <= r_s1_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_msg_id       = r_out_id;
    assign o_frame_length = r_out_len;
    assign o_byte_index   = r_out_idx;
    assign o_payload_byte = r_out_data;
    assign o_last         = r_out_last;

endmodule

[src/sum_checked_frame_receiver.sv]
// Sum-checked frame receiver: takes one byte per cycle while o_ready is high; a frame
// whose checksum matches is emitted one payload byte per transaction through the queue,
// read stage and registered output, one per cycle while the output is taken.
// Four frame slots buffer finished frames; input ready drops while all four wait.
// Synchronous active-low reset clears parser, queue and emitter control state;
// the payload buffer is not cleared. Depends on scf_pkg, scf_front, scf_fifo, scf_back.
module sum_checked_frame_receiver import scf_pkg::*; #(
    parameter int PAYLOAD_BOUND = P_PAYLOAD_BOUND
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_msg_id,
    output logic [4:0] o_frame_length,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    localparam int IDX_W = $clog2(PAYLOAD_BOUND);

    t_desc                   push_desc;
    t_desc                   pop_desc;
    logic                    push;
    logic                    pop;
    logic                    fifo_empty;
    logic                    fifo_full;
    logic                    frame_done;
    logic                    wr_en;
    logic [SLOT_W+IDX_W-1:0] wr_addr;
    logic [7:0]              wr_data;

    scf_front #(.PAYLOAD_BOUND(PAYLOAD_BOUND)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_desc       (push_desc),
        .o_push       (push),
        .i_frame_done (frame_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    scf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .i_pop   (pop),
        .o_data  (pop_desc),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    scf_back #(.PAYLOAD_BOUND(PAYLOAD_BOUND)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_desc         (pop_desc),
        .i_empty        (fifo_empty),
        .o_pop          (pop),
        .o_frame_done   (frame_done),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_msg_id       (o_msg_id),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_full)
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_empty)
        else $error("descriptor queue underflow");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_byte_index == o_frame_length - 5'd1))
        else $error("last mark on wrong byte index");

endmodule
